[hw/rtl/tcpf_pkg.sv]
// shared types and codes for the three-class priority fifo with cancel
package tcpf_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_ADD_LINK,
    S_USE,
    S_PEEK_USE,
    S_DONE
  } state_t;

  localparam int NCLASS     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam logic [1:0] CLASS_MILD = 2'd2;

endpackage

[hw/rtl/three_class_priority_fifo_with_cancel_top.sv]
// top level of the three-class priority fifo with cancel by key
//
// Holds up to CAPACITY keyed entries in three class queues (class 0 most
// urgent), each queue a doubly linked list through shared slot memories.
// Input channel in_*: in_tuser carries the kind (add, look up, peek, remove),
// in_tdata the key, age and severity. One result per input item leaves on
// out_* with status, peeked key and class, looked-up age and a flag that
// tells whether any class still holds an entry.
// Add, look up and remove walk every slot through the key memory, one
// slot per cycle, through the single read port of the slot memories;
// a peek reads only the oldest entry of the most urgent busy class.
// One item is in work at a time; in_tready is high only while the
// sequencer is idle.
// Results sit in an output register; a stalled receiver holds the result
// there, and the next item may still be taken while it waits, but its own
// result waits in the done state until the register frees.
// Reset (synchronous, active low) empties all classes and clears the slot
// valid bits; no clearing pass is needed, the block is ready right away.
module three_class_priority_fifo_with_cancel_top
  import tcpf_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key[31:0], age[39:32], severity[41:40]
  input  logic [1:0]            in_tuser,   // kind[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[2:0], key_out[34:3], age_out[42:35],
                                            // severity_out[44:43], waiting_any[45]
);

  localparam int IW = $clog2(CAPACITY);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  state_t state_r, state_nxt;

  // slot memories
  logic [KW-1:0] key_mem [CAPACITY];
  logic [7:0]    age_mem [CAPACITY];
  logic [1:0]    cls_mem [CAPACITY];
  logic [IW-1:0] ln_mem  [CAPACITY];
  logic [IW-1:0] lo_mem  [CAPACITY];
  logic [KW-1:0] key_rd_r;
  logic [7:0]    age_rd_r;
  logic [1:0]    cls_rd_r;
  logic [IW-1:0] ln_rd_r;
  logic [IW-1:0] lo_rd_r;

  logic [IW-1:0] rd_addr;
  logic          slot_we;
  logic          ln_we, lo_we;
  logic [IW-1:0] ln_wa, ln_wd, lo_wa, lo_wd;

  // control and class state
  logic [CAPACITY-1:0] valid_r;
  logic [NCLASS-1:0]   busy_r;
  logic [IW-1:0]       oldest_r [NCLASS];
  logic [IW-1:0]       newest_r [NCLASS];

  // per item registers
  kind_t         kind_r;
  logic [KW-1:0] key_r;
  logic [7:0]    age_r;
  logic [1:0]    sev_r;
  logic [IW-1:0] scan_r, chk_r, hit_idx_r, free_r, prev_r;
  logic          iss_en_r, chk_en_r, hit_r, free_found_r;
  status_t       res_status_r;
  logic [31:0]   res_key_r;
  logic [7:0]    res_age_r;
  logic [1:0]    res_sev_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic       in_xfer;
  logic [1:0] peek_cls;
  logic [1:0] in_sev_sat;
  logic [1:0] use_cls;
  logic       key_match;
  logic       add_ok;
  logic       out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // most urgent busy class
  always_comb begin
    if (busy_r[0])      peek_cls = 2'd0;
    else if (busy_r[1]) peek_cls = 2'd1;
    else                peek_cls = 2'd2;
  end

  assign in_sev_sat = (in_tdata[41:40] > CLASS_MILD) ? CLASS_MILD : in_tdata[41:40];
  assign use_cls    = (cls_rd_r > CLASS_MILD) ? CLASS_MILD : cls_rd_r;
  assign key_match  = chk_en_r && valid_r[chk_r] && (key_rd_r == key_r);
  assign add_ok     = (kind_r == KIND_ADD) && !hit_r && free_found_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (kind_t'(in_tuser) != KIND_PEEK) state_nxt = S_SCAN;
          else if (|busy_r)                   state_nxt = S_PEEK_USE;
          else                                state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (chk_en_r && chk_r == LAST) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (kind_r == KIND_ADD) begin
          state_nxt = (add_ok && busy_r[sev_r]) ? S_ADD_LINK : S_DONE;
        end else begin
          state_nxt = hit_r ? S_USE : S_DONE;
        end
      end
      S_ADD_LINK: state_nxt = S_DONE;
      S_USE:      state_nxt = S_DONE;
      S_PEEK_USE: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory read address and write controls
  always_comb begin
    rd_addr = '0;
    slot_we = 1'b0;
    ln_we   = 1'b0;
    lo_we   = 1'b0;
    ln_wa   = free_r;
    ln_wd   = free_r;
    lo_wa   = free_r;
    lo_wd   = free_r;
    case (state_r)
      S_IDLE:   rd_addr = oldest_r[peek_cls];
      S_SCAN:   rd_addr = scan_r;
      S_DECIDE: begin
        rd_addr = hit_idx_r;
        if (add_ok) begin
          slot_we = 1'b1;
          ln_we   = 1'b1;
          lo_we   = 1'b1;
          lo_wd   = busy_r[sev_r] ? newest_r[sev_r] : free_r;
        end
      end
      S_ADD_LINK: begin
        ln_we = 1'b1;
        ln_wa = prev_r;
      end
      S_USE: begin
        if (kind_r == KIND_REMOVE && hit_idx_r != oldest_r[use_cls] &&
            hit_idx_r != newest_r[use_cls]) begin
          ln_we = 1'b1;
          ln_wa = lo_rd_r;
          ln_wd = ln_rd_r;
          lo_we = 1'b1;
          lo_wa = ln_rd_r;
          lo_wd = lo_rd_r;
        end
      end
      default: rd_addr = '0;
    endcase
  end

  // slot memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (slot_we) begin
      key_mem[free_r] <= key_r;
      age_mem[free_r] <= age_r;
      cls_mem[free_r] <= sev_r;
    end
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    if (lo_we) lo_mem[lo_wa] <= lo_wd;
    key_rd_r <= key_mem[rd_addr];
    age_rd_r <= age_mem[rd_addr];
    cls_rd_r <= cls_mem[rd_addr];
    ln_rd_r  <= ln_mem[rd_addr];
    lo_rd_r  <= lo_mem[rd_addr];
  end

  // sequencer datapath and class state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      busy_r       <= '0;
      oldest_r     <= '{default: '0};
      newest_r     <= '{default: '0};
      iss_en_r     <= 1'b0;
      chk_en_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register: load from the done state, else free on transfer
      if (out_load)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            kind_r       <= kind_t'(in_tuser);
            key_r        <= in_tdata[KW-1:0];
            age_r        <= in_tdata[39:32];
            sev_r        <= in_sev_sat;
            scan_r       <= '0;
            iss_en_r     <= 1'b1;
            chk_en_r     <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            res_status_r <= ST_OK;
            res_key_r    <= '0;
            res_age_r    <= '0;
            res_sev_r    <= '0;
            if (kind_t'(in_tuser) == KIND_PEEK) begin
              if (|busy_r) res_sev_r <= peek_cls;
              else         res_status_r <= ST_EMPTY;
            end
          end
        end
        S_SCAN: begin
          // issue one slot read, compare the one read last cycle
          if (iss_en_r) begin
            if (!valid_r[scan_r] && !free_found_r) begin
              free_found_r <= 1'b1;
              free_r       <= scan_r;
            end
            chk_r    <= scan_r;
            chk_en_r <= 1'b1;
            if (scan_r == LAST) iss_en_r <= 1'b0;
            else                scan_r   <= scan_r + 1'b1;
          end else begin
            chk_en_r <= 1'b0;
          end
          if (key_match && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= chk_r;
          end
        end
        S_DECIDE: begin
          if (kind_r == KIND_ADD) begin
            if (hit_r)              res_status_r <= ST_DUPLICATE;
            else if (!free_found_r) res_status_r <= ST_FULL;
            else begin
              valid_r[free_r] <= 1'b1;
              newest_r[sev_r] <= free_r;
              prev_r          <= newest_r[sev_r];
              if (!busy_r[sev_r]) begin
                busy_r[sev_r]   <= 1'b1;
                oldest_r[sev_r] <= free_r;
              end
            end
          end else if (!hit_r) begin
            res_status_r <= ST_NOT_FOUND;
          end
        end
        S_USE: begin
          if (kind_r == KIND_LOOKUP) begin
            res_age_r <= age_rd_r;
          end else begin
            // unlink from its class queue
            valid_r[hit_idx_r] <= 1'b0;
            if (hit_idx_r == oldest_r[use_cls] && hit_idx_r == newest_r[use_cls])
              busy_r[use_cls] <= 1'b0;
            else if (hit_idx_r == newest_r[use_cls])
              newest_r[use_cls] <= lo_rd_r;
            else if (hit_idx_r == oldest_r[use_cls])
              oldest_r[use_cls] <= ln_rd_r;
          end
        end
        S_PEEK_USE: res_key_r <= 32'(key_rd_r);
        S_DONE: begin
          if (out_load) begin
            out_data_r <= {2'b00, |busy_r, res_sev_r, res_age_r, res_key_r,
                           res_status_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/tcpf_checker.sv]
// port-level checker for the priority fifo, bound to the top level
module tcpf_checker
  import tcpf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in work");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == ST_OK || out_tdata[2:0] == ST_DUPLICATE ||
                    out_tdata[2:0] == ST_NOT_FOUND || out_tdata[2:0] == ST_EMPTY ||
                    out_tdata[2:0] == ST_FULL))
    else $error("bad status code");

  // an empty status reports nothing waiting
  a_peek_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_EMPTY |-> !out_tdata[45])
    else $error("empty status while entries waiting");

endmodule

bind three_class_priority_fifo_with_cancel_top tcpf_checker u_tcpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
